/* rtl/core/iskl_pkg.sv */
// Shared types and constants for the INI section/key lookup block.
// Used by the rtl/core modules but iskl_fifo; depends on nothing else.
`timescale 1ns / 1ps

package iskl_pkg;

    // Longest section or key name that is compared, in bytes.
    localparam int unsigned NAME_MAX = 8;
    localparam int unsigned NAME_IW  = $clog2(NAME_MAX);

    // Byte codes the parser reacts to.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;

    // Configuration register indexes.
    localparam logic [1:0] REG_SECTION_NAME   = 2'd0;
    localparam logic [1:0] REG_SECTION_LENGTH = 2'd1;
    localparam logic [1:0] REG_KEY_NAME       = 2'd2;
    localparam logic [1:0] REG_KEY_LENGTH     = 2'd3;

    // Final status codes.
    typedef enum logic [1:0] {
        ST_FOUND      = 2'd0,
        ST_NO_SECTION = 2'd1,
        ST_NO_KEY     = 2'd2
    } status_t;

    // Parser modes.
    typedef enum logic [3:0] {
        MODE_LSTART = 4'd0,
        MODE_SKIP   = 4'd1,
        MODE_SLEAD  = 4'd2,
        MODE_SNAME  = 4'd3,
        MODE_STAIL  = 4'd4,
        MODE_SCLOSE = 4'd5,
        MODE_KNAME  = 4'd6,
        MODE_KEQ    = 4'd7,
        MODE_HSCAN  = 4'd8,
        MODE_VLEAD  = 4'd9,
        MODE_VDATA  = 4'd10
    } parse_mode_t;

    // Configuration register file.
    typedef struct packed {
        logic [63:0] section_name;
        logic [3:0]  section_length;
        logic [63:0] key_name;
        logic [3:0]  key_length;
    } cfg_t;

    // Byte classes worked out by the front end.
    typedef struct packed {
        logic le_space;   // byte up to 0x20, newline included
        logic blank;      // byte up to 0x20 other than newline
        logic newline;
        logic semi;
        logic equal;
        logic lbrack;
        logic rbrack;
    } char_class_t;

    // One classified item travelling from front end to parser.
    typedef struct packed {
        logic [7:0]          char_in;
        logic                eot;
        char_class_t         cls;
        logic [NAME_MAX-1:0] sec_hit;  // byte matches section name byte i
        logic [NAME_MAX-1:0] key_hit;  // byte matches key name byte i
    } item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] value_char;
        logic       value_valid;
        logic       done_res;
        status_t    status;
        logic [9:0] value_length;
    } result_t;

endpackage

/* rtl/core/iskl_fifo.sv */
// Small first-in first-out queue of register entries, full/empty handshake.
// Generic; used for the classified item queue and the result queue.
`timescale 1ns / 1ps

module iskl_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; no reset needed for payload.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

/* rtl/core/iskl_front.sv */
// Front end: accepts text bytes, classifies them and compares them against
// every name byte, then queues them. Depends on iskl_pkg and iskl_fifo.
`timescale 1ns / 1ps

module iskl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          char_in,
    input  logic                end_of_text,
    input  iskl_pkg::cfg_t      cfg,
    input  logic                item_pop,
    output iskl_pkg::item_t     item,
    output logic                item_empty
);

    localparam int unsigned IW = $bits(iskl_pkg::item_t);

    iskl_pkg::item_t item_in;
    logic [IW-1:0]   q_dout;

    // Letters compare without case.
    function automatic logic same_char(input logic [7:0] c, input logic [7:0] w);
        logic letter;
        begin
            letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
            same_char = (c == w) || (((c ^ w) == iskl_pkg::CH_SPACE) && letter);
        end
    endfunction

    // Byte classes and name comparisons.
    always_comb
    begin
        item_in.char_in        = char_in;
        item_in.eot            = end_of_text;
        item_in.cls.le_space   = (char_in <= iskl_pkg::CH_SPACE);
        item_in.cls.newline    = (char_in == iskl_pkg::CH_NEWLINE);
        item_in.cls.blank      = (char_in <= iskl_pkg::CH_SPACE) &&
                                 (char_in != iskl_pkg::CH_NEWLINE);
        item_in.cls.semi       = (char_in == iskl_pkg::CH_SEMI);
        item_in.cls.equal      = (char_in == iskl_pkg::CH_EQUAL);
        item_in.cls.lbrack     = (char_in == iskl_pkg::CH_LBRACK);
        item_in.cls.rbrack     = (char_in == iskl_pkg::CH_RBRACK);
        for (int i = 0; i < iskl_pkg::NAME_MAX; i++)
        begin
            item_in.sec_hit[i] = same_char(char_in, cfg.section_name[8*i +: 8]);
            item_in.key_hit[i] = same_char(char_in, cfg.key_name[8*i +: 8]);
        end
    end

    // Queue between front end and parser.
    iskl_fifo #(
        .WIDTH (IW),
        .DEPTH (2)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (item_in),
        .full  (full),
        .pop   (item_pop),
        .dout  (q_dout),
        .empty (item_empty)
    );

    assign item = iskl_pkg::item_t'(q_dout);

endmodule

/* rtl/core/iskl_parse.sv */
// Back end: the line parser state machine; one queued item per cycle unless stalled.
// Depends on iskl_pkg; fed by iskl_front, feeds the result queue.
`timescale 1ns / 1ps

module iskl_parse #(
    parameter int unsigned VALUE_MAX = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  iskl_pkg::cfg_t       cfg,
    input  iskl_pkg::item_t      item,
    input  logic                 item_empty,
    output logic                 item_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output iskl_pkg::result_t    res
);

    localparam int unsigned CW = $clog2(VALUE_MAX + 1);
    localparam logic [CW-1:0] VMAX = CW'(VALUE_MAX);
    localparam logic [3:0] NMAX = 4'(iskl_pkg::NAME_MAX);

    iskl_pkg::parse_mode_t mode_reg, mode_next;
    logic [3:0]    mpos_reg, mpos_next;
    logic          seen_reg, seen_next;
    logic          inside_reg, inside_next;
    logic          header_reg, header_next;
    logic          fin_reg, fin_next;
    logic          aux_reg, aux_next;
    logic          lastrb_reg, lastrb_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [3:0]        sec_len, key_len;
    logic              take;
    logic              res_valid;
    logic [CW+9:0]     cnt_ext;
    iskl_pkg::result_t found_res;

    // An item is taken when one waits and the result queue has room.
    assign take     = !item_empty && !res_full;
    assign item_pop = take;
    assign res_push = take && res_valid;

    // Names longer than the compare window count as the window.
    assign sec_len = (cfg.section_length > NMAX) ? NMAX : cfg.section_length;
    assign key_len = (cfg.key_length > NMAX) ? NMAX : cfg.key_length;

    // Final report for a found key; a value ending in ']' on a '[' line reports no key.
    assign cnt_ext = {10'd0, cnt_reg};
    always_comb
    begin
        found_res             = '0;
        found_res.done_res    = 1'b1;
        if (header_reg && (cnt_reg != '0) && lastrb_reg)
        begin
            found_res.status = iskl_pkg::ST_NO_KEY;
        end
        else
        begin
            found_res.status       = iskl_pkg::ST_FOUND;
            found_res.value_length = cnt_ext[9:0];
        end
    end

    // Next state; a byte may pass through up to three modes combinationally.
    always_comb
    begin
        logic go;
        mode_next   = mode_reg;
        mpos_next   = mpos_reg;
        seen_next   = seen_reg;
        inside_next = inside_reg;
        header_next = header_reg;
        fin_next    = fin_reg;
        aux_next    = aux_reg;
        lastrb_next = lastrb_reg;
        cnt_next    = cnt_reg;
        res         = '0;
        res_valid   = 1'b0;
        go          = 1'b0;

        if (item.eot)
        begin
            // End of text: report unless already reported, then restart.
            if (!fin_reg)
            begin
                res_valid = 1'b1;
                if ((mode_reg == iskl_pkg::MODE_VLEAD) || (mode_reg == iskl_pkg::MODE_VDATA))
                begin
                    res = found_res;
                end
                else
                begin
                    res.done_res = 1'b1;
                    res.status   = (seen_reg || ((mode_reg == iskl_pkg::MODE_SCLOSE) && aux_reg))
                                   ? iskl_pkg::ST_NO_KEY : iskl_pkg::ST_NO_SECTION;
                end
            end
            mode_next   = iskl_pkg::MODE_LSTART;
            mpos_next   = '0;
            seen_next   = 1'b0;
            inside_next = 1'b0;
            header_next = 1'b0;
            fin_next    = 1'b0;
            aux_next    = 1'b0;
            lastrb_next = 1'b0;
            cnt_next    = '0;
        end
        else if (!fin_reg)
        begin
            go = 1'b1;
        end

        for (int pass = 0; pass < 3; pass++)
        begin
            if (go)
            begin
                go = 1'b0;
                unique case (mode_next)
                    iskl_pkg::MODE_LSTART:
                    begin
                        if (!item.cls.le_space)
                        begin
                            if (item.cls.semi)
                            begin
                                mode_next = iskl_pkg::MODE_SKIP;
                            end
                            else if (inside_next)
                            begin
                                header_next = item.cls.lbrack;
                                mpos_next   = '0;
                                mode_next   = iskl_pkg::MODE_KNAME;
                                go          = 1'b1;
                            end
                            else if (item.cls.lbrack)
                            begin
                                mode_next = iskl_pkg::MODE_SLEAD;
                            end
                            else
                            begin
                                mode_next = iskl_pkg::MODE_SKIP;
                            end
                        end
                    end
                    iskl_pkg::MODE_SLEAD:
                    begin
                        if (!item.cls.blank)
                        begin
                            mpos_next = '0;
                            mode_next = iskl_pkg::MODE_SNAME;
                            go        = 1'b1;
                        end
                    end
                    iskl_pkg::MODE_SNAME:
                    begin
                        if (!item.cls.newline && (mpos_next < sec_len) &&
                            item.sec_hit[mpos_next[iskl_pkg::NAME_IW-1:0]])
                        begin
                            mpos_next = mpos_next + 4'd1;
                        end
                        else
                        begin
                            aux_next  = (mpos_next == sec_len);
                            mode_next = iskl_pkg::MODE_STAIL;
                            go        = 1'b1;
                        end
                    end
                    iskl_pkg::MODE_STAIL:
                    begin
                        if (!item.cls.blank)
                        begin
                            if (item.cls.rbrack)
                            begin
                                mode_next = iskl_pkg::MODE_SCLOSE;
                            end
                            else
                            begin
                                mode_next = item.cls.newline ? iskl_pkg::MODE_LSTART
                                                             : iskl_pkg::MODE_SKIP;
                            end
                        end
                    end
                    iskl_pkg::MODE_SCLOSE:
                    begin
                        if (!item.cls.blank)
                        begin
                            if (item.cls.newline)
                            begin
                                if (aux_next)
                                begin
                                    inside_next = 1'b1;
                                    seen_next   = 1'b1;
                                end
                                mode_next = iskl_pkg::MODE_LSTART;
                            end
                            else
                            begin
                                mode_next = iskl_pkg::MODE_SKIP;
                            end
                        end
                    end
                    iskl_pkg::MODE_KNAME:
                    begin
                        if (!item.cls.newline && (mpos_next < key_len) &&
                            item.key_hit[mpos_next[iskl_pkg::NAME_IW-1:0]])
                        begin
                            mpos_next = mpos_next + 4'd1;
                        end
                        else if (mpos_next == key_len)
                        begin
                            mode_next = iskl_pkg::MODE_KEQ;
                            go        = 1'b1;
                        end
                        else if (header_next)
                        begin
                            aux_next  = 1'b0;
                            mode_next = iskl_pkg::MODE_HSCAN;
                            go        = 1'b1;
                        end
                        else
                        begin
                            mode_next = item.cls.newline ? iskl_pkg::MODE_LSTART
                                                         : iskl_pkg::MODE_SKIP;
                        end
                    end
                    iskl_pkg::MODE_KEQ:
                    begin
                        if (!item.cls.blank)
                        begin
                            if (item.cls.equal)
                            begin
                                mode_next = iskl_pkg::MODE_VLEAD;
                            end
                            else
                            begin
                                mode_next = item.cls.newline ? iskl_pkg::MODE_LSTART
                                                             : iskl_pkg::MODE_SKIP;
                            end
                        end
                    end
                    iskl_pkg::MODE_HSCAN:
                    begin
                        // Track whether the last non-blank byte of the line is ']'.
                        if (item.cls.newline)
                        begin
                            if (aux_next)
                            begin
                                inside_next = 1'b0;
                            end
                            mode_next = iskl_pkg::MODE_LSTART;
                        end
                        else if (!item.cls.blank)
                        begin
                            aux_next = item.cls.rbrack;
                        end
                    end
                    iskl_pkg::MODE_VLEAD:
                    begin
                        if (!item.cls.blank)
                        begin
                            mode_next = iskl_pkg::MODE_VDATA;
                            go        = 1'b1;
                        end
                    end
                    iskl_pkg::MODE_VDATA:
                    begin
                        if (item.cls.newline)
                        begin
                            res       = found_res;
                            res_valid = 1'b1;
                            fin_next  = 1'b1;
                        end
                        else
                        begin
                            lastrb_next = item.cls.rbrack;
                            if (cnt_next < VMAX)
                            begin
                                cnt_next          = cnt_next + CW'(1);
                                res.value_char    = item.char_in;
                                res.value_valid   = 1'b1;
                                res_valid         = 1'b1;
                            end
                        end
                    end
                    iskl_pkg::MODE_SKIP:
                    begin
                        if (item.cls.newline)
                        begin
                            mode_next = iskl_pkg::MODE_LSTART;
                        end
                    end
                    default:
                    begin
                        mode_next = iskl_pkg::MODE_SKIP;
                    end
                endcase
            end
        end
    end

    // Parser state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= iskl_pkg::MODE_LSTART;
            mpos_reg   <= '0;
            seen_reg   <= 1'b0;
            inside_reg <= 1'b0;
            header_reg <= 1'b0;
            fin_reg    <= 1'b0;
            aux_reg    <= 1'b0;
            lastrb_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            mpos_reg   <= mpos_next;
            seen_reg   <= seen_next;
            inside_reg <= inside_next;
            header_reg <= header_next;
            fin_reg    <= fin_next;
            aux_reg    <= aux_next;
            lastrb_reg <= lastrb_next;
            cnt_reg    <= cnt_next;
        end
    end

    // A result is either a value byte or the final report, never both.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !(res.value_valid && res.done_res))
        else $error("result marked both value byte and final report");

    // The kept value length never passes its limit.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= VMAX)
        else $error("value count above limit");

    // After the report only end of text is acted on, and silently.
    a_quiet_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        take && fin_reg |-> !res_push)
        else $error("result after final report");

    // A final report mid-text leaves the parser finished.
    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res.done_res && !item.eot |=> fin_reg)
        else $error("parser not finished after report");

endmodule

/* rtl/core/ini_section_key_lookup.sv */
// Top level of the INI section/key lookup: config registers, front end,
// parser and result queue. Depends on iskl_pkg, iskl_front, iskl_parse, iskl_fifo.
//
//   Channel   Handshake         Payload
//   ------    ---------------   ---------------------------------------------------
//   text in   push / full       char_in, end_of_text
//   results   empty / pop       value_char, value_valid, done_res, status, value_length
//   config    cfg_we            cfg_index, cfg_data
//
// One text byte is taken every cycle while full is low; the parser walks each byte
// through up to three modes combinationally and holds it while the result queue is
// full. A byte is registered in the input queue, its result in the result queue.
// Two-entry queues on both sides of the parser let input and output stall apart;
// full rises only when the result side has been stalled long enough to back up.
// Reset clears the configuration registers to zero and the parser to line start.
`timescale 1ns / 1ps

module ini_section_key_lookup #(
    parameter int unsigned VALUE_MAX = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_in,
    input  logic        end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  value_char,
    output logic        value_valid,
    output logic        done_res,
    output logic [1:0]  status,
    output logic [9:0]  value_length,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int unsigned RW = $bits(iskl_pkg::result_t);

    iskl_pkg::cfg_t    cfg_reg;
    iskl_pkg::item_t   item;
    logic              item_empty;
    logic              item_pop;
    logic              res_full;
    logic              res_push;
    iskl_pkg::result_t res_in;
    iskl_pkg::result_t res_out;
    logic [RW-1:0]     rq_dout;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                iskl_pkg::REG_SECTION_NAME:   cfg_reg.section_name   <= cfg_data;
                iskl_pkg::REG_SECTION_LENGTH: cfg_reg.section_length <= cfg_data[3:0];
                iskl_pkg::REG_KEY_NAME:       cfg_reg.key_name       <= cfg_data;
                iskl_pkg::REG_KEY_LENGTH:     cfg_reg.key_length     <= cfg_data[3:0];
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Byte classification and input queue.
    iskl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .char_in     (char_in),
        .end_of_text (end_of_text),
        .cfg         (cfg_reg),
        .item_pop    (item_pop),
        .item        (item),
        .item_empty  (item_empty)
    );

    // Line parser.
    iskl_parse #(
        .VALUE_MAX (VALUE_MAX)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (item),
        .item_empty (item_empty),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    // Result queue toward the consumer.
    iskl_fifo #(
        .WIDTH (RW),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (rq_dout),
        .empty (empty)
    );

    assign res_out      = iskl_pkg::result_t'(rq_dout);
    assign value_char   = res_out.value_char;
    assign value_valid  = res_out.value_valid;
    assign done_res     = res_out.done_res;
    assign status       = res_out.status;
    assign value_length = res_out.value_length;

endmodule

/* tb/tb_ini_section_key_lookup.sv */
// Self-checking testbench for ini_section_key_lookup: feeds INI text byte by byte and
// checks every result against an in-bench parser model or a directed expected result.
// Depends on iskl_pkg and the ini_section_key_lookup RTL.
`timescale 1ns / 1ps

module tb_ini_section_key_lookup;

    localparam int unsigned VALUE_LIMIT   = 512;
    localparam int unsigned ITEM_TARGET   = 1700;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_TEXT     = 3;

    // Kinds of configuration picked between texts.
    localparam int CFG_RANDOM = 0;
    localparam int CFG_EMPTY  = 1;
    localparam int CFG_FULL   = 2;
    localparam int CFG_OVER   = 3;
    localparam int CFG_CLEAN  = 4;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } text_item_t;

    typedef struct packed {
        logic [7:0]        ch;
        logic              eot;
        logic              typed;
        iskl_pkg::result_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  char_in;
    logic        end_of_text;
    logic        empty;
    logic        pop;
    logic [7:0]  value_char;
    logic        value_valid;
    logic        done_res;
    logic [1:0]  status;
    logic [9:0]  value_length;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    ini_section_key_lookup #(
        .VALUE_MAX(VALUE_LIMIT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .char_in(char_in),
        .end_of_text(end_of_text),
        .empty(empty),
        .pop(pop),
        .value_char(value_char),
        .value_valid(value_valid),
        .done_res(done_res),
        .status(status),
        .value_length(value_length),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Parser model state and its copy of the configuration registers.
    iskl_pkg::parse_mode_t mode;
    logic [3:0]  mpos;
    bit          sec_seen;
    bit          in_sec;
    bit          hdr_line;
    bit          fin;
    bit          line_flag;
    int unsigned vcount;
    logic [7:0]  last_val;
    logic [63:0] want_sec;
    logic [3:0]  want_sec_len;
    logic [63:0] want_key;
    logic [3:0]  want_key_len;

    iskl_pkg::result_t pending_results[$];
    text_item_t        text_q[$];
    dir_row_t          dir_rows[$];

    // Generator view of the configuration in force.
    logic [63:0] gen_sec;
    logic [3:0]  gen_sec_len;
    logic [63:0] gen_key;
    logic [3:0]  gen_key_len;

    int                mismatches = 0;
    int                live_items = 0;
    int                burst_left = 0;
    bit                steady = 1'b0;
    bit                cur_typed = 1'b0;
    iskl_pkg::result_t cur_want = '0;

    function automatic bit is_blank(input logic [7:0] c);
        return (c <= iskl_pkg::CH_SPACE) && (c != iskl_pkg::CH_NEWLINE);
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // Letters match regardless of case; everything else must be equal.
    function automatic bit same_char(input logic [7:0] c, input logic [7:0] w);
        return (c == w) || (((c ^ w) == 8'h20) && is_letter(c));
    endfunction

    function automatic logic [7:0] name_char(input logic [63:0] name, input int unsigned idx);
        return name[8 * idx +: 8];
    endfunction

    // Lengths above the compare width count as the full width.
    function automatic int unsigned name_len(input logic [3:0] len);
        return (len > iskl_pkg::NAME_MAX) ? iskl_pkg::NAME_MAX : len;
    endfunction

    function automatic iskl_pkg::result_t status_only(input iskl_pkg::status_t st,
                                                      input logic [9:0] len);
        iskl_pkg::result_t r;
        r = '0;
        r.done_res = 1'b1;
        r.status = st;
        r.value_length = len;
        return r;
    endfunction

    // A bracketed key line whose value ends in ']' is a header, not a key hit.
    function automatic iskl_pkg::result_t found_result();
        if (hdr_line && vcount > 0 && last_val == iskl_pkg::CH_RBRACK)
            return status_only(iskl_pkg::ST_NO_KEY, 10'd0);
        return status_only(iskl_pkg::ST_FOUND, vcount[9:0]);
    endfunction

    task automatic clear_parser();
        mode = iskl_pkg::MODE_LSTART;
        mpos = '0;
        sec_seen = 1'b0;
        in_sec = 1'b0;
        hdr_line = 1'b0;
        fin = 1'b0;
        line_flag = 1'b0;
        vcount = 0;
        last_val = 8'h00;
    endtask

    // Advances the parser model by one text item and returns the result it causes.
    task automatic scan_byte(input logic [7:0] c, input logic eot, output bit got,
                             output iskl_pkg::result_t r);
        bit          again;
        int unsigned n;
        got = 1'b0;
        r = '0;
        if (eot)
        begin
            if (!fin)
            begin
                if (mode == iskl_pkg::MODE_SCLOSE && line_flag)
                    sec_seen = 1'b1;
                if (mode == iskl_pkg::MODE_VLEAD || mode == iskl_pkg::MODE_VDATA)
                    r = found_result();
                else
                    r = status_only(sec_seen ? iskl_pkg::ST_NO_KEY : iskl_pkg::ST_NO_SECTION,
                                    10'd0);
                got = 1'b1;
            end
            clear_parser();
        end
        else if (!fin)
        begin
            do
            begin
                again = 1'b0;
                case (mode)
                    iskl_pkg::MODE_LSTART:
                        if (c > iskl_pkg::CH_SPACE)
                        begin
                            if (c == iskl_pkg::CH_SEMI)
                                mode = iskl_pkg::MODE_SKIP;
                            else if (in_sec)
                            begin
                                hdr_line = (c == iskl_pkg::CH_LBRACK);
                                mpos = '0;
                                mode = iskl_pkg::MODE_KNAME;
                                again = 1'b1;
                            end
                            else if (c == iskl_pkg::CH_LBRACK)
                                mode = iskl_pkg::MODE_SLEAD;
                            else
                                mode = iskl_pkg::MODE_SKIP;
                        end
                    iskl_pkg::MODE_SLEAD:
                        if (!is_blank(c))
                        begin
                            mpos = '0;
                            mode = iskl_pkg::MODE_SNAME;
                            again = 1'b1;
                        end
                    iskl_pkg::MODE_SNAME:
                    begin
                        n = name_len(want_sec_len);
                        if (c != iskl_pkg::CH_NEWLINE && mpos < n &&
                            same_char(c, name_char(want_sec, mpos)))
                            mpos = mpos + 1'b1;
                        else
                        begin
                            line_flag = (mpos == n);
                            mode = iskl_pkg::MODE_STAIL;
                            again = 1'b1;
                        end
                    end
                    iskl_pkg::MODE_STAIL:
                        if (!is_blank(c))
                        begin
                            if (c == iskl_pkg::CH_RBRACK)
                                mode = iskl_pkg::MODE_SCLOSE;
                            else
                                mode = (c == iskl_pkg::CH_NEWLINE) ? iskl_pkg::MODE_LSTART
                                                                   : iskl_pkg::MODE_SKIP;
                        end
                    iskl_pkg::MODE_SCLOSE:
                        if (!is_blank(c))
                        begin
                            if (c == iskl_pkg::CH_NEWLINE)
                            begin
                                if (line_flag)
                                begin
                                    in_sec = 1'b1;
                                    sec_seen = 1'b1;
                                end
                                mode = iskl_pkg::MODE_LSTART;
                            end
                            else
                                mode = iskl_pkg::MODE_SKIP;
                        end
                    iskl_pkg::MODE_KNAME:
                    begin
                        n = name_len(want_key_len);
                        if (c != iskl_pkg::CH_NEWLINE && mpos < n &&
                            same_char(c, name_char(want_key, mpos)))
                            mpos = mpos + 1'b1;
                        else if (mpos == n)
                        begin
                            mode = iskl_pkg::MODE_KEQ;
                            again = 1'b1;
                        end
                        else if (hdr_line)
                        begin
                            line_flag = 1'b0;
                            mode = iskl_pkg::MODE_HSCAN;
                            again = 1'b1;
                        end
                        else
                            mode = (c == iskl_pkg::CH_NEWLINE) ? iskl_pkg::MODE_LSTART
                                                               : iskl_pkg::MODE_SKIP;
                    end
                    iskl_pkg::MODE_KEQ:
                        if (!is_blank(c))
                        begin
                            if (c == iskl_pkg::CH_EQUAL)
                                mode = iskl_pkg::MODE_VLEAD;
                            else
                                mode = (c == iskl_pkg::CH_NEWLINE) ? iskl_pkg::MODE_LSTART
                                                                   : iskl_pkg::MODE_SKIP;
                        end
                    iskl_pkg::MODE_HSCAN:
                        if (c == iskl_pkg::CH_NEWLINE)
                        begin
                            if (line_flag)
                                in_sec = 1'b0;
                            mode = iskl_pkg::MODE_LSTART;
                        end
                        else if (!is_blank(c))
                            line_flag = (c == iskl_pkg::CH_RBRACK);
                    iskl_pkg::MODE_VLEAD:
                        if (!is_blank(c))
                        begin
                            mode = iskl_pkg::MODE_VDATA;
                            again = 1'b1;
                        end
                    iskl_pkg::MODE_VDATA:
                        if (c == iskl_pkg::CH_NEWLINE)
                        begin
                            r = found_result();
                            fin = 1'b1;
                            got = 1'b1;
                        end
                        else
                        begin
                            // Bytes past the limit are dropped silently.
                            last_val = c;
                            if (vcount < VALUE_LIMIT)
                            begin
                                vcount++;
                                r.value_char = c;
                                r.value_valid = 1'b1;
                                got = 1'b1;
                            end
                        end
                    iskl_pkg::MODE_SKIP:
                        if (c == iskl_pkg::CH_NEWLINE)
                            mode = iskl_pkg::MODE_LSTART;
                    default:
                        mode = iskl_pkg::MODE_SKIP;
                endcase
            end
            while (again);
        end
    endtask

    task automatic note_mismatch(input string what, input iskl_pkg::result_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected char=%02h valid=%b done=%b status=%0d len=%0d",
                     $time, what, want.value_char, want.value_valid, want.done_res,
                     want.status, want.value_length);
        if (mismatches <= 10)
            $display("    got char=%02h valid=%b done=%b status=%0d len=%0d",
                     value_char, value_valid, done_res, status, value_length);
    endtask

    // Tracks config writes, predicts each accepted item and checks each accepted result.
    always @(posedge clk)
    begin : monitor
        bit                got;
        iskl_pkg::result_t r;
        iskl_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    iskl_pkg::REG_SECTION_NAME:   want_sec = cfg_data;
                    iskl_pkg::REG_SECTION_LENGTH: want_sec_len = cfg_data[3:0];
                    iskl_pkg::REG_KEY_NAME:       want_key = cfg_data;
                    iskl_pkg::REG_KEY_LENGTH:     want_key_len = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (push && !full)
            begin
                live_items++;
                scan_byte(char_in, end_of_text, got, r);
                if (cur_typed)
                    pending_results.push_back(cur_want);
                else if (got)
                    pending_results.push_back(r);
            end
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                    note_mismatch("result with nothing pending", '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (value_char !== want.value_char || value_valid !== want.value_valid ||
                        done_res !== want.done_res || status !== want.status ||
                        value_length !== want.value_length)
                        note_mismatch("result mismatch", want);
                end
            end
        end
    end

    // Receiver stalls follow a repeating 16-bit pattern that is replaced now and then.
    always @(negedge clk)
    begin : pop_driver
        logic [15:0] pop_pattern;
        logic [3:0]  pattern_pos;
        int          pattern_left;
        logic [31:0] raw;
        if (pattern_left <= 0)
        begin
            raw = $urandom & $urandom & $urandom;
            case ($urandom_range(0, 5))
                0: pop_pattern = 16'hFFFF;
                1: pop_pattern = raw[15:0] | 16'h0001;
                default:
                begin
                    raw = $urandom;
                    pop_pattern = raw[15:0] | 16'h0001;
                end
            endcase
            pattern_pos = 4'd0;
            pattern_left = $urandom_range(50, 400);
        end
        pattern_left--;
        pop <= pop_pattern[pattern_pos];
        pattern_pos = pattern_pos + 1'b1;
    end

    // Sends one text item, with the sender working in bursts split by gaps.
    task automatic send_item(input logic [7:0] ch, input logic eot, input bit typed,
                             input iskl_pkg::result_t want);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                push <= 1'b0;
                char_in <= 8'($urandom_range(0, 255));
                end_of_text <= 1'($urandom_range(0, 1));
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        push <= 1'b1;
        char_in <= ch;
        end_of_text <= eot;
        cur_typed = typed;
        cur_want = want;
        do
            @(posedge clk);
        while (full);
    endtask

    // Stops sending and waits until every pending result has been taken.
    task automatic drain_results();
        @(negedge clk);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input logic [63:0] sec, input logic [3:0] slen,
                                input logic [63:0] key, input logic [3:0] klen);
        logic [63:0] len_word;
        gen_sec = sec;
        gen_sec_len = slen;
        gen_key = key;
        gen_key_len = klen;
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= iskl_pkg::REG_SECTION_NAME;
        cfg_data <= sec;
        // Bits above the length field are ignored, so they carry noise.
        len_word = {$urandom, $urandom};
        len_word[3:0] = slen;
        @(negedge clk);
        cfg_index <= iskl_pkg::REG_SECTION_LENGTH;
        cfg_data <= len_word;
        @(negedge clk);
        cfg_index <= iskl_pkg::REG_KEY_NAME;
        cfg_data <= key;
        len_word = {$urandom, $urandom};
        len_word[3:0] = klen;
        @(negedge clk);
        cfg_index <= iskl_pkg::REG_KEY_LENGTH;
        cfg_data <= len_word;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pool_char();
        int unsigned pick;
        pick = $urandom_range(0, 38);
        if (pick < 26)
            return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + pick);
        if (pick < 36)
            return 8'(8'h30 + (pick - 26));
        if (pick == 36)
            return ".";
        if (pick == 37)
            return "_";
        return "-";
    endfunction

    // Name bytes beyond the compared length keep their random fill.
    function automatic logic [63:0] make_name(input logic [3:0] len, input bit clean,
                                              input bit may_bracket);
        logic [63:0] name;
        name = {$urandom, $urandom};
        for (int i = 0; i < name_len(len); i++)
        begin
            if (!clean && $urandom_range(0, 15) == 0)
                name[8 * i +: 8] = 8'($urandom_range(0, 255));
            else
                name[8 * i +: 8] = pool_char();
        end
        if (may_bracket && !clean && $urandom_range(0, 4) == 0)
            name[7:0] = iskl_pkg::CH_LBRACK;
        return name;
    endfunction

    function automatic logic [3:0] rand_len();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 4'd0;
        if (pick == 1)
            return 4'($urandom_range(9, 15));
        return 4'($urandom_range(1, 8));
    endfunction

    task automatic pick_config(input int kind);
        logic [3:0] slen;
        logic [3:0] klen;
        case (kind)
            CFG_EMPTY:
            begin
                slen = 4'd0;
                klen = 4'd0;
            end
            CFG_FULL:
            begin
                slen = 4'd8;
                klen = 4'd8;
            end
            CFG_OVER:
            begin
                slen = 4'd15;
                klen = 4'($urandom_range(9, 15));
            end
            CFG_CLEAN:
            begin
                slen = 4'($urandom_range(1, 8));
                klen = 4'($urandom_range(1, 8));
            end
            default:
            begin
                slen = rand_len();
                klen = rand_len();
            end
        endcase
        write_config(make_name(slen, kind == CFG_CLEAN, 1'b0), slen,
                     make_name(klen, kind == CFG_CLEAN, 1'b1), klen);
    endtask

    task automatic put_byte(input logic [7:0] b);
        text_item_t t;
        t.ch = b;
        t.eot = 1'b0;
        text_q.push_back(t);
    endtask

    // Blanks are mostly spaces, sometimes any control byte but newline.
    task automatic put_blanks(input int unsigned most);
        logic [7:0] b;
        repeat ($urandom_range(0, most))
        begin
            b = iskl_pkg::CH_SPACE;
            if ($urandom_range(0, 3) == 0)
            begin
                b = 8'($urandom_range(0, 32));
                if (b == iskl_pkg::CH_NEWLINE)
                    b = iskl_pkg::CH_SPACE;
            end
            put_byte(b);
        end
    endtask

    task automatic put_name(input logic [63:0] name, input int unsigned cnt);
        logic [7:0] b;
        for (int i = 0; i < cnt; i++)
        begin
            b = name_char(name, i);
            if (is_letter(b) && $urandom_range(0, 1))
                b = b ^ 8'h20;
            put_byte(b);
        end
    endtask

    task automatic put_filler(input int unsigned n, input bit bracket_end);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            if (bracket_end && i == n - 1)
                b = iskl_pkg::CH_RBRACK;
            else if ($urandom_range(0, 7) == 0)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == iskl_pkg::CH_NEWLINE)
                    b = 8'h7F;
            end
            else
                b = 8'($urandom_range(33, 126));
            put_byte(b);
        end
    endtask

    // Builds one INI text: mostly headers and key lines, with comments and noise mixed in.
    task automatic build_text(input bit long_value);
        int unsigned pick;
        int unsigned v;
        int unsigned slen;
        int unsigned klen;
        text_item_t  t;
        slen = name_len(gen_sec_len);
        klen = name_len(gen_key_len);
        text_q.delete();
        if (long_value)
        begin
            put_byte(iskl_pkg::CH_LBRACK);
            put_name(gen_sec, slen);
            put_byte(iskl_pkg::CH_RBRACK);
            put_byte(iskl_pkg::CH_NEWLINE);
            put_name(gen_key, klen);
            put_byte(iskl_pkg::CH_EQUAL);
            put_filler($urandom_range(VALUE_LIMIT + 3, VALUE_LIMIT + 20), 1'b0);
            put_byte(iskl_pkg::CH_NEWLINE);
        end
        repeat ($urandom_range(1, 8))
        begin
            pick = $urandom_range(0, 19);
            v = $urandom_range(0, 7);
            put_blanks(2);
            if (pick < 2)
            begin
                put_byte(iskl_pkg::CH_SEMI);
                put_filler($urandom_range(0, 8), 1'b0);
            end
            else if (pick < 6)
            begin
                // Wanted header, sometimes one byte long or short, or badly closed.
                put_byte(iskl_pkg::CH_LBRACK);
                put_blanks(2);
                put_name(gen_sec, (v == 1 && slen > 0) ? slen - 1 : slen);
                if (v == 0)
                    put_byte(pool_char());
                put_blanks(2);
                if (v != 3)
                    put_byte(iskl_pkg::CH_RBRACK);
                put_blanks(1);
                if (v == 2)
                    put_filler(2, 1'b0);
            end
            else if (pick < 8)
            begin
                // Some other header; a stray bracket after it keeps the line open.
                put_byte(iskl_pkg::CH_LBRACK);
                repeat ($urandom_range(1, 6)) put_byte(pool_char());
                put_byte(iskl_pkg::CH_RBRACK);
                if (v == 0)
                begin
                    put_byte(iskl_pkg::CH_SPACE);
                    put_byte(pool_char());
                end
                if (v == 1)
                    put_byte(iskl_pkg::CH_RBRACK);
            end
            else if (pick < 14)
            begin
                // Key line, sometimes short, long or missing the equal sign.
                put_name(gen_key, (v == 1 && klen > 0) ? klen - 1 : klen);
                if (v == 2)
                    put_byte(pool_char());
                put_blanks(2);
                if (v != 0)
                    put_byte(iskl_pkg::CH_EQUAL);
                put_blanks(2);
                put_filler($urandom_range(0, 12), $urandom_range(0, 3) == 0);
            end
            else if (pick < 17)
            begin
                repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
            end
            if (pick < 14 || pick >= 17 || $urandom_range(0, 3) != 0)
                put_byte(iskl_pkg::CH_NEWLINE);
        end
        // Sometimes the text ends in the middle of its last line.
        if ($urandom_range(0, 4) == 0 && text_q[$].ch == iskl_pkg::CH_NEWLINE)
            void'(text_q.pop_back());
        t.ch = 8'($urandom_range(0, 255));
        t.eot = 1'b1;
        text_q.push_back(t);
        if ($urandom_range(0, 7) == 0)
            text_q.push_back(t);
    endtask

    task automatic add_row(input logic [7:0] ch, input logic eot, input logic typed,
                           input iskl_pkg::result_t want);
        dir_row_t row;
        row.ch = ch;
        row.eot = eot;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i], 1'b0, 1'b0, '0);
    endtask

    // Safety net against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int text_no;
        bit long_text;
        rst_n = 1'b0;
        push = 1'b0;
        char_in = 8'h00;
        end_of_text = 1'b0;
        cfg_we = 1'b0;
        cfg_index = iskl_pkg::REG_SECTION_NAME;
        cfg_data = '0;
        want_sec = '0;
        want_sec_len = '0;
        want_key = '0;
        want_key_len = '0;
        clear_parser();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: first row runs on the reset configuration.
        add_row(8'h00, 1'b1, 1'b1, status_only(iskl_pkg::ST_NO_SECTION, 10'd0));
        add_text(" [ sX ]\n");
        add_text("K = ");
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(iskl_pkg::CH_NEWLINE, 1'b0, 1'b1, status_only(iskl_pkg::ST_FOUND, 10'd1));
        // After the report, bytes and the end of text give nothing.
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b0, '0);
        add_text("[sx]\n");
        add_row(8'h5A, 1'b1, 1'b1, status_only(iskl_pkg::ST_NO_KEY, 10'd0));
        foreach (dir_rows[i])
        begin
            if (i == 1)
            begin
                drain_results();
                // Section "sX", key "k".
                write_config(64'h0000_0000_0000_5873, 4'd2, 64'h0000_0000_0000_006B, 4'd1);
            end
            send_item(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random texts, reconfigured now and then; the first few use edge settings.
        text_no = 0;
        while (live_items < ITEM_TARGET)
        begin
            long_text = (text_no == LONG_TEXT);
            if (text_no <= LONG_TEXT || $urandom_range(0, 1) == 0)
            begin
                drain_results();
                case (text_no)
                    0: pick_config(CFG_EMPTY);
                    1: pick_config(CFG_FULL);
                    2: pick_config(CFG_OVER);
                    LONG_TEXT: pick_config(CFG_CLEAN);
                    default: pick_config(($urandom_range(0, 7) == 0) ? CFG_CLEAN : CFG_RANDOM);
                endcase
            end
            else if ($urandom_range(0, 7) == 0)
                drain_results();
            steady = ($urandom_range(0, 3) == 0);
            build_text(long_text);
            foreach (text_q[i])
                send_item(text_q[i].ch, text_q[i].eot, 1'b0, '0);
            text_no++;
        end

        drain_results();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/iskl_pkg.sv
rtl/core/iskl_fifo.sv
rtl/core/iskl_front.sv
rtl/core/iskl_parse.sv
rtl/core/ini_section_key_lookup.sv
tb/tb_ini_section_key_lookup.sv
